/* rtl/core/irs_pkg.sv */
package irs_pkg;

   localparam int CORDIC_W   = 34;
   localparam int SQRT_W     = 61;
   localparam int SQRT_STEPS = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [CORDIC_W-1:0] Q30_POS = 34'sh0_4000_0000;
   localparam logic signed [CORDIC_W-1:0] Q30_NEG = -34'sh0_4000_0000;

   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
      32'h00000000, 32'h00000000
   };

   localparam logic [CSR_IDX_W-1:0] REG_BOUNDING_RADIUS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Z        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_THRESH_FIRST    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_THRESH_SECOND   = 3'd5;

   localparam logic [1:0] LINE_FIRST  = 2'd0;
   localparam logic [1:0] LINE_SECOND = 2'd1;
   localparam logic [1:0] LINE_THIRD  = 2'd2;

   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic [SQRT_W-1:0] v;
      logic [SQRT_W-1:0] r;
   } sqrt_type;

   typedef struct packed {
      logic signed [31:0] cos_v;
      logic signed [31:0] sin_v;
   } trig_type;

   typedef struct packed {
      cordic_type         dis;
      cordic_type         azi;
      logic [1:0]         dis_quad;
      logic [1:0]         azi_quad;
      sqrt_type           rad;
      sqrt_type           pol;
      logic signed [31:0] cos_t;
      logic [31:0]        line_frac;
   } cell_type;

   typedef struct packed {
      logic [29:0]        radius;
      logic signed [30:0] origin_x;
      logic signed [30:0] origin_y;
      logic signed [30:0] origin_z;
      logic [23:0]        thresh_first;
      logic [23:0]        thresh_second;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic [1:0]         line_index;
      logic [10:0]        energy_kev;
   } result_type;

   function automatic cordic_type cordic_step(input cordic_type c, input int shift,
                                              input logic [31:0] angle);
      cordic_type n;
      if (!c.z[CORDIC_W-1]) begin
         n.x = c.x - (c.y >>> shift);
         n.y = c.y + (c.x >>> shift);
         n.z = c.z - CORDIC_W'(angle);
      end else begin
         n.x = c.x + (c.y >>> shift);
         n.y = c.y - (c.x >>> shift);
         n.z = c.z + CORDIC_W'(angle);
      end
      return n;
   endfunction

   function automatic sqrt_type sqrt_step(input sqrt_type s, input logic [SQRT_W-1:0] b);
      sqrt_type          n;
      logic [SQRT_W-1:0] t;
      t = s.r + b;
      if (s.v >= t) begin
         n.v = s.v - t;
         n.r = (s.r >> 1) + b;
      end else begin
         n.v = s.v;
         n.r = s.r >> 1;
      end
      return n;
   endfunction

   function automatic logic signed [31:0] clamp_q30(input logic signed [CORDIC_W-1:0] v);
      logic signed [CORDIC_W-1:0] c;
      c = (v > Q30_POS) ? Q30_POS : ((v < Q30_NEG) ? Q30_NEG : v);
      return 32'(c);
   endfunction

   function automatic trig_type cordic_fold(input cordic_type c, input logic [1:0] quad);
      trig_type           t;
      logic signed [31:0] x;
      logic signed [31:0] y;
      x = clamp_q30(c.x);
      y = clamp_q30(c.y);
      case (quad)
         QUAD_SECOND: begin t.cos_v = -y; t.sin_v = x;  end
         QUAD_THIRD:  begin t.cos_v = -x; t.sin_v = -y; end
         QUAD_FOURTH: begin t.cos_v = y;  t.sin_v = -x; end
         default:     begin t.cos_v = x;  t.sin_v = y;  end
      endcase
      return t;
   endfunction

   function automatic logic signed [63:0] round30(input logic signed [63:0] v);
      return (v + 64'sh2000_0000) >>> 30;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] c;
      c = (v > 64'sh7FFF_FFFF) ? 64'sh7FFF_FFFF :
          ((v < -64'sh8000_0000) ? -64'sh8000_0000 : v);
      return 32'(c);
   endfunction

   function automatic logic signed [15:0] clamp_dir(input logic signed [63:0] v);
      logic signed [63:0] c;
      c = (v > 64'sd32767) ? 64'sd32767 : ((v < -64'sd32767) ? -64'sd32767 : v);
      return 16'(c);
   endfunction

   // Q60 product to Q1.15, negated
   function automatic logic signed [15:0] dir_q15(input logic signed [63:0] prod);
      return clamp_dir((-prod + 64'sh0000_1000_0000_0000) >>> 45);
   endfunction

   function automatic logic [10:0] energy_of(input logic [1:0] line);
      logic [10:0] e;
      case (line)
         LINE_FIRST:  e = 11'd159;
         LINE_SECOND: e = 11'd460;
         default:     e = 11'd1460;
      endcase
      return e;
   endfunction

endpackage

/* rtl/core/irs_req_if.sv */
interface irs_req_if #(parameter int FRACTION_BITS = 24);
   logic                     valid;
   logic                     ready;
   logic [FRACTION_BITS-1:0] rand_disk_angle;
   logic [FRACTION_BITS-1:0] rand_disk_radius;
   logic [FRACTION_BITS-1:0] rand_polar;
   logic [FRACTION_BITS-1:0] rand_azimuth;
   logic [FRACTION_BITS-1:0] rand_line;

   modport source (output valid, rand_disk_angle, rand_disk_radius, rand_polar,
                   rand_azimuth, rand_line, input ready);
   modport sink   (input valid, rand_disk_angle, rand_disk_radius, rand_polar,
                   rand_azimuth, rand_line, output ready);
endinterface

/* rtl/core/irs_rsp_if.sv */
interface irs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic signed [15:0] dir_z;
   logic [1:0]         line_index;
   logic [10:0]        energy_kev;

   modport source (output valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                   line_index, energy_kev, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                   line_index, energy_kev, output ready);
endinterface

/* rtl/core/irs_csr_if.sv */
interface irs_csr_if import irs_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/irs_cell.sv */
module irs_cell import irs_pkg::*; #(
   parameter int STEP          = 0,
   parameter int CORDIC_STAGES = 20
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  cell_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output cell_type out_data
);

   localparam logic [4:0] AtanIdx   = 5'(STEP);
   localparam int         SqrtShift = (STEP < SQRT_STEPS) ? 2 * (SQRT_STEPS - 1 - STEP) : 0;
   localparam logic [SQRT_W-1:0] SqrtBit = SQRT_W'(1) << SqrtShift;

   logic     valid_ff, valid_in;
   cell_type data_ff, data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in = in_data;
      if (STEP < CORDIC_STAGES) begin
         data_in.dis = cordic_step(in_data.dis, STEP, ATAN_TURNS[AtanIdx]);
         data_in.azi = cordic_step(in_data.azi, STEP, ATAN_TURNS[AtanIdx]);
      end
      if (STEP < SQRT_STEPS) begin
         data_in.rad = sqrt_step(in_data.rad, SqrtBit);
         data_in.pol = sqrt_step(in_data.pol, SqrtBit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/core/irs_calc.sv */
module irs_calc import irs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   output logic       in_ready,
   input  cell_type   in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   typedef struct packed {
      trig_type           dis;
      trig_type           azi;
      logic signed [31:0] sr;
      logic signed [31:0] st;
      logic signed [31:0] ct;
      logic [31:0]        fl;
   } s0_type;

   typedef struct packed {
      trig_type           dis;
      trig_type           azi;
      logic signed [31:0] ct;
      logic signed [31:0] st;
      logic signed [63:0] dr_p;
      logic signed [63:0] a_p;
      logic signed [63:0] b_p;
      logic signed [63:0] dx_p;
      logic signed [63:0] dy_p;
      logic signed [15:0] dir_z;
      logic [1:0]         line;
   } s1_type;

   typedef struct packed {
      trig_type           azi;
      logic signed [31:0] ct;
      logic signed [31:0] st;
      logic signed [63:0] px_p;
      logic signed [63:0] py_p;
      logic signed [63:0] a_p;
      logic signed [63:0] b_p;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic [1:0]         line;
   } s2_type;

   typedef struct packed {
      trig_type           azi;
      logic signed [31:0] py;
      logic signed [63:0] p1;
      logic signed [63:0] p2;
      logic signed [63:0] a_p;
      logic signed [63:0] b_p;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic [1:0]         line;
   } s3_type;

   typedef struct packed {
      logic signed [63:0] q1;
      logic signed [63:0] q2;
      logic signed [63:0] q3;
      logic signed [63:0] q4;
      logic signed [31:0] z1;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic [1:0]         line;
   } s4_type;

   logic [5:0] vld_ff, vld_in, rdy, ld;
   s0_type     s0_ff, s0_in;
   s1_type     s1_ff, s1_in;
   s2_type     s2_ff, s2_in;
   s3_type     s3_ff, s3_in;
   s4_type     s4_ff, s4_in;
   result_type s5_ff, s5_in;

   logic signed [31:0] radius_s;
   logic signed [31:0] dr, px, x1;
   logic signed [63:0] x2, y2;

   always_comb begin
      rdy[5] = !vld_ff[5] || out_ready;
      for (int k = 0; k < 5; k++) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      ld[0]     = in_valid && rdy[0];
      vld_in[0] = rdy[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < 6; k++) begin
         ld[k]     = vld_ff[k-1] && rdy[k];
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[5];
   assign out_data  = s5_ff;
   assign radius_s  = signed'({2'b00, cfg.radius});

   // quadrant fold and square-root results
   always_comb begin
      s0_in.dis = cordic_fold(in_data.dis, in_data.dis_quad);
      s0_in.azi = cordic_fold(in_data.azi, in_data.azi_quad);
      s0_in.sr  = signed'({1'b0, in_data.rad.r[30:0]});
      s0_in.st  = signed'({1'b0, in_data.pol.r[30:0]});
      s0_in.ct  = in_data.cos_t;
      s0_in.fl  = in_data.line_frac;
   end

   always_comb begin
      s1_in.dis   = s0_ff.dis;
      s1_in.azi   = s0_ff.azi;
      s1_in.ct    = s0_ff.ct;
      s1_in.st    = s0_ff.st;
      s1_in.dr_p  = s0_ff.sr * radius_s;
      s1_in.a_p   = radius_s * s0_ff.st;
      s1_in.b_p   = radius_s * s0_ff.ct;
      s1_in.dx_p  = s0_ff.st * s0_ff.azi.cos_v;
      s1_in.dy_p  = s0_ff.st * s0_ff.azi.sin_v;
      s1_in.dir_z = clamp_dir((-64'(s0_ff.ct) + 64'sh4000) >>> 15);
      if (s0_ff.fl < {cfg.thresh_first, 8'h00}) begin
         s1_in.line = LINE_FIRST;
      end else if (s0_ff.fl < {cfg.thresh_second, 8'h00}) begin
         s1_in.line = LINE_SECOND;
      end else begin
         s1_in.line = LINE_THIRD;
      end
   end

   always_comb begin
      dr          = 32'(round30(s1_ff.dr_p));
      s2_in.azi   = s1_ff.azi;
      s2_in.ct    = s1_ff.ct;
      s2_in.st    = s1_ff.st;
      s2_in.px_p  = dr * s1_ff.dis.cos_v;
      s2_in.py_p  = dr * s1_ff.dis.sin_v;
      s2_in.a_p   = s1_ff.a_p;
      s2_in.b_p   = s1_ff.b_p;
      s2_in.dir_x = dir_q15(s1_ff.dx_p);
      s2_in.dir_y = dir_q15(s1_ff.dy_p);
      s2_in.dir_z = s1_ff.dir_z;
      s2_in.line  = s1_ff.line;
   end

   always_comb begin
      px          = 32'(round30(s2_ff.px_p));
      s3_in.azi   = s2_ff.azi;
      s3_in.py    = 32'(round30(s2_ff.py_p));
      s3_in.p1    = px * s2_ff.ct;
      s3_in.p2    = px * s2_ff.st;
      s3_in.a_p   = s2_ff.a_p;
      s3_in.b_p   = s2_ff.b_p;
      s3_in.dir_x = s2_ff.dir_x;
      s3_in.dir_y = s2_ff.dir_y;
      s3_in.dir_z = s2_ff.dir_z;
      s3_in.line  = s2_ff.line;
   end

   // turn about y, then products for the turn about z
   always_comb begin
      x1          = 32'(round30(s3_ff.p1 + s3_ff.a_p));
      s4_in.z1    = 32'(round30(s3_ff.b_p - s3_ff.p2));
      s4_in.q1    = x1 * s3_ff.azi.cos_v;
      s4_in.q2    = s3_ff.py * s3_ff.azi.sin_v;
      s4_in.q3    = x1 * s3_ff.azi.sin_v;
      s4_in.q4    = s3_ff.py * s3_ff.azi.cos_v;
      s4_in.dir_x = s3_ff.dir_x;
      s4_in.dir_y = s3_ff.dir_y;
      s4_in.dir_z = s3_ff.dir_z;
      s4_in.line  = s3_ff.line;
   end

   always_comb begin
      x2               = round30(s4_ff.q1 - s4_ff.q2);
      y2               = round30(s4_ff.q3 + s4_ff.q4);
      s5_in.pos_x      = sat32(x2 + 64'(cfg.origin_x));
      s5_in.pos_y      = sat32(y2 + 64'(cfg.origin_y));
      s5_in.pos_z      = sat32(64'(s4_ff.z1) + 64'(cfg.origin_z));
      s5_in.dir_x      = s4_ff.dir_x;
      s5_in.dir_y      = s4_ff.dir_y;
      s5_in.dir_z      = s4_ff.dir_z;
      s5_in.line_index = s4_ff.line;
      s5_in.energy_kev = energy_of(s4_ff.line);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) s0_ff <= s0_in;
      if (ld[1]) s1_ff <= s1_in;
      if (ld[2]) s2_ff <= s2_in;
      if (ld[3]) s3_ff <= s3_in;
      if (ld[4]) s4_ff <= s4_in;
      if (ld[5]) s5_ff <= s5_in;
   end

endmodule

/* rtl/core/isotropic_ray_sampler_unit.sv */
// Channel  Port    Dir  Carries
// request  req_ch  in   five uniform fractions
// result   rsp_ch  out  start point, direction, energy line
// config   csr_ch  in   register index and write data
//
// One request per cycle unless rsp_ch stalls; requests pass the intake register,
// CELLS = max(CORDIC_STAGES, 31) CORDIC / square-root cells (31 square-root bit steps), irs_calc.
// Synchronous reset clears all valid flags and loads the register defaults.
// Every stage holds its own valid flag, so bubbles close up while rsp_ch stalls
// and requests keep entering until the whole chain is full.
module isotropic_ray_sampler_unit import irs_pkg::*; #(
   parameter int FRACTION_BITS = 24,
   parameter int CORDIC_STAGES = 20
) (
   input logic     clock,
   input logic     reset,
   irs_req_if.sink req_ch,
   irs_rsp_if.source rsp_ch,
   irs_csr_if.sink csr_ch
);

   localparam int Cells = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

   cfg_type    cfg_ff;
   logic       intake_valid_ff, intake_ready;
   cell_type   intake_ff, intake_in;
   logic [Cells:0] chain_valid, chain_ready;
   cell_type   chain_data [Cells+1];
   result_type result;

   logic [31:0] f_dis, f_rad, f_pol, f_azi;
   logic [29:0] pol_a;
   logic [30:0] pol_comp;

   function automatic logic [31:0] frac32(input logic [FRACTION_BITS-1:0] u);
      return 32'(u) << (32 - FRACTION_BITS);
   endfunction

   // configuration registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius        <= 30'd256000;
         cfg_ff.origin_x      <= '0;
         cfg_ff.origin_y      <= '0;
         cfg_ff.origin_z      <= '0;
         cfg_ff.thresh_first  <= 24'd5939134;
         cfg_ff.thresh_second <= 24'd11525947;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_BOUNDING_RADIUS: cfg_ff.radius        <= csr_ch.data[29:0];
            REG_ORIGIN_X:        cfg_ff.origin_x      <= csr_ch.data;
            REG_ORIGIN_Y:        cfg_ff.origin_y      <= csr_ch.data;
            REG_ORIGIN_Z:        cfg_ff.origin_z      <= csr_ch.data;
            REG_THRESH_FIRST:    cfg_ff.thresh_first  <= csr_ch.data[23:0];
            REG_THRESH_SECOND:   cfg_ff.thresh_second <= csr_ch.data[23:0];
            default: ;
         endcase
      end
   end

   // intake: align fractions, seed CORDIC and square-root cells
   always_comb begin
      f_dis    = frac32(req_ch.rand_disk_angle);
      f_rad    = frac32(req_ch.rand_disk_radius);
      f_pol    = frac32(req_ch.rand_polar);
      f_azi    = frac32(req_ch.rand_azimuth);
      pol_a    = f_pol[31:2];
      pol_comp = 31'h4000_0000 - {1'b0, pol_a};

      intake_in.dis      = '{x: CORDIC_GAIN_Q30, y: '0, z: CORDIC_W'(f_dis[29:0])};
      intake_in.azi      = '{x: CORDIC_GAIN_Q30, y: '0, z: CORDIC_W'(f_azi[29:0])};
      intake_in.dis_quad = f_dis[31:30];
      intake_in.azi_quad = f_azi[31:30];
      intake_in.rad.v    = SQRT_W'({f_rad[31:2], 30'd0});
      intake_in.rad.r    = '0;
      // 2^60 - cos^2 = 4a(2^30 - a) with cos = 2a - 2^30
      intake_in.pol.v    = SQRT_W'(64'({pol_a, 2'b00}) * 64'(pol_comp));
      intake_in.pol.r    = '0;
      intake_in.cos_t    = signed'({1'b0, pol_a, 1'b0}) - 32'sh4000_0000;
      intake_in.line_frac = frac32(req_ch.rand_line);
   end

   assign intake_ready = !intake_valid_ff || chain_ready[0];
   assign req_ch.ready = intake_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         intake_valid_ff <= 1'b0;
      end else if (intake_ready) begin
         intake_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && intake_ready) begin
         intake_ff <= intake_in;
      end
   end

   assign chain_valid[0] = intake_valid_ff;
   assign chain_data[0]  = intake_ff;

   for (genvar g = 0; g < Cells; g++) begin : g_cell
      irs_cell #(
         .STEP          (g),
         .CORDIC_STAGES (CORDIC_STAGES)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   irs_calc u_calc (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (chain_valid[Cells]),
      .in_ready  (chain_ready[Cells]),
      .in_data   (chain_data[Cells]),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (result)
   );

   assign rsp_ch.pos_x      = result.pos_x;
   assign rsp_ch.pos_y      = result.pos_y;
   assign rsp_ch.pos_z      = result.pos_z;
   assign rsp_ch.dir_x      = result.dir_x;
   assign rsp_ch.dir_y      = result.dir_y;
   assign rsp_ch.dir_z      = result.dir_z;
   assign rsp_ch.line_index = result.line_index;
   assign rsp_ch.energy_kev = result.energy_kev;

endmodule
